>>> rtl/core/pcof_pkg.sv
package pcof_pkg;

  localparam int MaxPointsDef  = 64;
  localparam int CoordBitsDef  = 16;
  localparam int FieldW        = 16;
  localparam int PctW          = 7;
  localparam logic [PctW-1:0] PctReset = 7'd90;

  // floor(x / 100) == (x * RecipHundred) >> RecipShift for x < 8192
  localparam int RecipShift = 22;
  localparam logic [RecipShift-1:0] RecipHundred = 22'd41944;

  typedef struct packed {
    logic clear;
    logic sample;
  } rank_ctl_t;

endpackage

>>> rtl/core/pcof_dist_unit.sv
module pcof_dist_unit import pcof_pkg::*; #(
  parameter int CW   = CoordBitsDef,
  parameter int CNTW = 7,
  parameter int SW   = CW + CNTW,
  parameter int DW   = CW + CNTW + 1,
  parameter int DSW  = 2 * DW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CNTW-1:0]   n_i,
  input  logic [3*CW-1:0]   coord_i,
  input  logic [3*SW-1:0]   sum_i,
  output logic              done_o,
  output logic [DSW-1:0]    dist_o
);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_MUL  = 5'b00010,
    PH_SUB  = 5'b00100,
    PH_SQ   = 5'b01000,
    PH_ACC  = 5'b10000
  } phase_e;

  phase_e ph_q, ph_d;
  logic [1:0] ax_q, ax_d;
  logic signed [2*DW-1:0] prod_q, prod_d;
  logic signed [DW-1:0] mag_q, mag_d;
  logic [DSW-1:0] acc_q, acc_d;
  logic done_q, done_d;

  logic signed [CW-1:0] p_sel;
  logic signed [SW-1:0] s_sel;
  logic signed [DW-1:0] op_a, op_b, diff;
  logic signed [2*DW-1:0] mul;

  assign p_sel = $signed(coord_i[ax_q*CW +: CW]);
  assign s_sel = $signed(sum_i[ax_q*SW +: SW]);
  assign diff  = $signed(prod_q[DW-1:0]) - DW'(s_sel);

  // one multiplier: n * p first, then the square of |n * p - s|
  always_comb begin
    if (ph_q == PH_MUL) begin
      op_a = DW'($signed({1'b0, n_i}));
      op_b = DW'(p_sel);
    end else begin
      op_a = mag_q;
      op_b = mag_q;
    end
  end
  assign mul = op_a * op_b;

  always_comb begin
    ph_d   = ph_q;
    ax_d   = ax_q;
    prod_d = prod_q;
    mag_d  = mag_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    unique case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          acc_d = '0;
          ax_d  = '0;
          ph_d  = PH_MUL;
        end
      end
      PH_MUL: begin
        prod_d = mul;
        ph_d   = PH_SUB;
      end
      PH_SUB: begin
        mag_d = diff[DW-1] ? -diff : diff;
        ph_d  = PH_SQ;
      end
      PH_SQ: begin
        prod_d = mul;
        ph_d   = PH_ACC;
      end
      PH_ACC: begin
        acc_d = acc_q + DSW'($unsigned(prod_q));
        if (ax_q == 2'd2) begin
          done_d = 1'b1;
          ph_d   = PH_IDLE;
        end else begin
          ax_d = ax_q + 2'd1;
          ph_d = PH_MUL;
        end
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      ax_q   <= '0;
      prod_q <= '0;
      mag_q  <= '0;
      acc_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      ax_q   <= ax_d;
      prod_q <= prod_d;
      mag_q  <= mag_d;
      acc_q  <= acc_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign dist_o = acc_q;

endmodule

>>> rtl/core/pcof_rank_unit.sv
module pcof_rank_unit import pcof_pkg::*; #(
  parameter int CNTW = 7,
  parameter int DSW  = 50
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rank_ctl_t       ctl_i,
  input  logic [DSW-1:0]  sample_i,
  input  logic [DSW-1:0]  cand_i,
  input  logic [CNTW-1:0] rank_i,
  output logic [CNTW-1:0] lt_o,
  output logic            hit_o
);

  logic [CNTW-1:0] lt_q, lt_d, le_q, le_d;

  always_comb begin
    lt_d = lt_q;
    le_d = le_q;
    if (ctl_i.clear) begin
      lt_d = '0;
      le_d = '0;
    end else if (ctl_i.sample) begin
      if (sample_i < cand_i) lt_d = lt_q + CNTW'(1);
      if (sample_i <= cand_i) le_d = le_q + CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= '0;
      le_q <= '0;
    end else begin
      lt_q <= lt_d;
      le_q <= le_d;
    end
  end

  assign lt_o  = lt_q;
  assign hit_o = (lt_q <= rank_i) && (rank_i < le_q);

endmodule

>>> rtl/core/point_cloud_outlier_filter_core.sv
// Point cloud outlier filter.
// Slave stream: one point per transaction, tdata = {z, y, x}, tlast marks the final point.
// Points load at one per cycle into a point memory while the coordinate sums grow.
// After the final point the block drops s_axis_tready and works on the whole set:
//   distance: one point at a time, through the shared multiplier of the distance unit
//             (n*p, subtract sum, square, accumulate for each of three axes);
//   rank:     one stored distance compared per cycle against each candidate in turn
//             until the cut value is found;
//   emit:     stored points read and checked in order; a kept one waits while the master stalls.
// Master stream: kept points in input order, tlast on the last one, tuser = {overflowed,
// none_kept}. A set with no kept point gives one none_kept result with zero coordinates.
// A result waits in the output register when m_axis_tready is low; the scan holds meanwhile.
// The next set may start loading while the last result of a run still waits.
// Config channel writes quantile_percent (reset 90); write it only between sets.
// Reset clears the sums, count, overflow flag and sequencer; memories need no clearing.
module point_cloud_outlier_filter_core import pcof_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [47:0]     s_axis_tdata,   // coord_x, coord_y, coord_z
  input  logic            s_axis_tlast,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [47:0]     m_axis_tdata,   // kept_x, kept_y, kept_z
  output logic            m_axis_tlast,
  output logic [1:0]      m_axis_tuser,   // overflowed, none_kept
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [PctW-1:0] cfg_data_i
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int CW   = COORD_BITS;
  localparam int IW   = (CW > FieldW) ? CW : FieldW;
  localparam int SW   = CW + CNTW;
  localparam int DW   = CW + CNTW + 1;
  localparam int DSW  = 2 * DW;
  localparam int KPW  = CNTW + PctW;

  typedef enum logic [9:0] {
    S_LOAD      = 10'b0000000001,
    S_DIST_RD   = 10'b0000000010,
    S_DIST_RUN  = 10'b0000000100,
    S_RANK_V    = 10'b0000001000,
    S_RANK_LD   = 10'b0000010000,
    S_RANK_SCAN = 10'b0000100000,
    S_RANK_EVAL = 10'b0001000000,
    S_EMIT_RD   = 10'b0010000000,
    S_EMIT_CHK  = 10'b0100000000,
    S_EMPTY     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d, j_q, j_d, k_q, k_d, kept_q, kept_d, emit_q, emit_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic signed [SW-1:0] sum_q [3];
  logic signed [SW-1:0] sum_d [3];
  logic ovf_q, ovf_d, smp_q, smp_d;
  logic [PctW-1:0] pct_q;
  logic [DSW-1:0] v_q, v_d, q_q, q_d;

  logic out_vld_q, out_vld_d, out_last_q, out_last_d, out_none_q, out_none_d;
  logic out_ovf_q, out_ovf_d;
  logic [47:0] out_data_q, out_data_d;

  logic [3*CW-1:0] pmem [MAX_POINTS];
  logic [DSW-1:0]  dmem [MAX_POINTS];
  logic [3*CW-1:0] prd_q, pwdata;
  logic [DSW-1:0]  drd_q;
  logic [AW-1:0]   dra;
  logic pwe, dwe;

  logic [CW-1:0] in_raw [3];
  logic [SW*3-1:0] sum_bus;
  logic dist_start, dist_done;
  logic [DSW-1:0] dist_val;
  rank_ctl_t rank_ctl;
  logic [CNTW-1:0] lt;
  logic hit, accept, slot_free, last_pt;
  logic [KPW-1:0] kp;
  logic [KPW+RecipShift-1:0] kq;
  logic [CNTW-1:0] k_raw;
  logic [IW-1:0] ext [3];
  logic [IW-1:0] oext [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ext[a]    = IW'(s_axis_tdata[a*FieldW +: FieldW]);
      in_raw[a] = ext[a][CW-1:0];
      oext[a]   = IW'($signed(prd_q[a*CW +: CW]));
    end
  end
  assign pwdata  = {in_raw[2], in_raw[1], in_raw[0]};
  assign sum_bus = {sum_q[2], sum_q[1], sum_q[0]};

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_vld_q || m_axis_tready;
  assign last_pt   = (CNTW'(ptr_q) == cnt_q - CNTW'(1));
  assign pwe       = accept && (cnt_q != CNTW'(MAX_POINTS));
  assign dwe       = (state_q == S_DIST_RUN) && dist_done;
  assign dra       = (state_q == S_RANK_SCAN) ? j_q[AW-1:0] : ptr_q;

  // rank = min(floor(n * pct / 100), n - 1)
  assign kp    = KPW'(cnt_q) * KPW'(pct_q);
  assign kq    = (KPW+RecipShift)'(kp) * (KPW+RecipShift)'(RecipHundred);
  assign k_raw = CNTW'(kq >> RecipShift);

  always_ff @(posedge clk_i) begin
    if (pwe) pmem[cnt_q[AW-1:0]] <= pwdata;
    if (dwe) dmem[ptr_q] <= dist_val;
    prd_q <= pmem[ptr_q];
    drd_q <= dmem[dra];
  end

  assign dist_start = (state_q == S_DIST_RD);
  assign rank_ctl.clear  = (state_q == S_RANK_LD);
  assign rank_ctl.sample = smp_q;

  pcof_dist_unit #(.CW(CW), .CNTW(CNTW), .SW(SW), .DW(DW), .DSW(DSW)) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .n_i     (cnt_q),
    .coord_i (prd_q),
    .sum_i   (sum_bus),
    .done_o  (dist_done),
    .dist_o  (dist_val)
  );

  pcof_rank_unit #(.CNTW(CNTW), .DSW(DSW)) u_rank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (rank_ctl),
    .sample_i (drd_q),
    .cand_i   (v_q),
    .rank_i   (k_q),
    .lt_o     (lt),
    .hit_o    (hit)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    ovf_d      = ovf_q;
    ptr_d      = ptr_q;
    j_d        = j_q;
    k_d        = k_q;
    kept_d     = kept_q;
    emit_d     = emit_q;
    v_d        = v_q;
    q_d        = q_q;
    smp_d      = 1'b0;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_last_d = out_last_q;
    out_none_d = out_none_q;
    out_ovf_d  = out_ovf_q;
    out_data_d = out_data_q;
    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (pwe) begin
            for (int a = 0; a < 3; a++) sum_d[a] = sum_q[a] + SW'($signed(in_raw[a]));
            cnt_d = cnt_q + CNTW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            ptr_d   = '0;
            state_d = S_DIST_RD;
          end
        end
      end
      S_DIST_RD: state_d = S_DIST_RUN;
      S_DIST_RUN: begin
        if (dist_done) begin
          if (last_pt) begin
            ptr_d   = '0;
            k_d     = (k_raw >= cnt_q) ? cnt_q - CNTW'(1) : k_raw;
            state_d = S_RANK_V;
          end else begin
            ptr_d   = ptr_q + AW'(1);
            state_d = S_DIST_RD;
          end
        end
      end
      S_RANK_V: state_d = S_RANK_LD;
      S_RANK_LD: begin
        v_d     = drd_q;
        j_d     = '0;
        state_d = S_RANK_SCAN;
      end
      S_RANK_SCAN: begin
        if (j_q == cnt_q) begin
          state_d = S_RANK_EVAL;
        end else begin
          smp_d = 1'b1;
          j_d   = j_q + CNTW'(1);
        end
      end
      S_RANK_EVAL: begin
        if (hit) begin
          q_d     = v_q;
          kept_d  = lt;
          emit_d  = '0;
          ptr_d   = '0;
          state_d = (lt == '0) ? S_EMPTY : S_EMIT_RD;
        end else begin
          ptr_d   = ptr_q + AW'(1);
          state_d = S_RANK_V;
        end
      end
      S_EMIT_RD: state_d = S_EMIT_CHK;
      S_EMIT_CHK: begin
        if (drd_q < q_q) begin
          if (slot_free) begin
            out_vld_d  = 1'b1;
            out_none_d = 1'b0;
            out_ovf_d  = ovf_q;
            out_last_d = (emit_q + CNTW'(1) == kept_q);
            out_data_d = {oext[2][FieldW-1:0], oext[1][FieldW-1:0], oext[0][FieldW-1:0]};
            emit_d     = emit_q + CNTW'(1);
            if (emit_q + CNTW'(1) == kept_q) begin
              cnt_d   = '0;
              ovf_d   = 1'b0;
              for (int a = 0; a < 3; a++) sum_d[a] = '0;
              state_d = S_LOAD;
            end else begin
              ptr_d   = ptr_q + AW'(1);
              state_d = S_EMIT_RD;
            end
          end
        end else begin
          ptr_d   = ptr_q + AW'(1);
          state_d = S_EMIT_RD;
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_none_d = 1'b1;
          out_ovf_d  = ovf_q;
          out_last_d = 1'b1;
          out_data_d = '0;
          cnt_d      = '0;
          ovf_d      = 1'b0;
          for (int a = 0; a < 3; a++) sum_d[a] = '0;
          state_d    = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      cnt_q      <= '0;
      for (int a = 0; a < 3; a++) sum_q[a] <= '0;
      ovf_q      <= 1'b0;
      ptr_q      <= '0;
      j_q        <= '0;
      k_q        <= '0;
      kept_q     <= '0;
      emit_q     <= '0;
      v_q        <= '0;
      q_q        <= '0;
      smp_q      <= 1'b0;
      pct_q      <= PctReset;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      out_none_q <= 1'b0;
      out_ovf_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      sum_q      <= sum_d;
      ovf_q      <= ovf_d;
      ptr_q      <= ptr_d;
      j_q        <= j_d;
      k_q        <= k_d;
      kept_q     <= kept_d;
      emit_q     <= emit_d;
      v_q        <= v_d;
      q_q        <= q_d;
      smp_q      <= smp_d;
      if (cfg_valid_i) pct_q <= cfg_data_i;
      out_vld_q  <= out_vld_d;
      out_last_q <= out_last_d;
      out_none_q <= out_none_d;
      out_ovf_q  <= out_ovf_d;
      out_data_q <= out_data_d;
    end
  end

  assign s_axis_tready = (state_q == S_LOAD);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_ovf_q, out_none_q};

endmodule

>>> rtl/core/pcof_checker.sv
module pcof_checker import pcof_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_none_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 48'd0))
    else $error("none_kept result malformed");

  a_busy_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken during filtering");

  // the run is still going while a non-final result is shown
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken before run ended");

endmodule

bind point_cloud_outlier_filter_core pcof_checker u_pcof_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
